[design/get_pkg.sv]
// Package: constants, codes and shared types of the grouped entry table.
package get_pkg;

    localparam int MAX_GROUPS = 16;
    localparam int CAPACITY   = 32;
    localparam int ID_BITS    = 16;
    localparam int GRP_W      = 4;
    localparam int ATK_W      = 16;
    localparam int RID_W      = 16;
    localparam int TALLY_W    = 6;
    localparam int CFG_W      = 5;
    localparam int SLOT_W     = $clog2(CAPACITY);
    localparam int USED_W     = $clog2(CAPACITY + 1);
    localparam int QDEPTH     = 2;

    typedef enum logic [1:0] {
        CMD_ENTER  = 2'd0,
        CMD_FIND   = 2'd1,
        CMD_REMOVE = 2'd2,
        CMD_INFO   = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        KIND_ENTERED = 3'd0,
        KIND_HEADER  = 3'd1,
        KIND_MEMBER  = 3'd2,
        KIND_REMOVED = 3'd3,
        KIND_INFO    = 3'd4,
        KIND_ERROR   = 3'd5
    } kind_t;

    // Operation after classification by the front part
    typedef enum logic [2:0] {
        OP_ENTER,
        OP_FIND,
        OP_REMOVE,
        OP_INFO,
        OP_ERROR
    } op_t;

    typedef struct packed {
        op_t               op;
        logic [GRP_W-1:0]  grp;
        logic [ID_BITS-1:0] id;
        logic [ATK_W-1:0]  atk;
    } work_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_COUNT,
        ST_HEADER,
        ST_SCAN,
        ST_SHIFT,
        ST_SINGLE
    } state_t;

    typedef struct packed {
        logic [2:0]         kind;
        logic [GRP_W-1:0]   grp;
        logic [RID_W-1:0]   id;
        logic [TALLY_W-1:0] tally;
        logic               last;
    } result_t;

endpackage

[design/get_if.sv]
// Interfaces: valid/ready channels for commands and results.
interface get_cmd_if;
    logic                          valid;
    logic                          ready;
    logic [1:0]                    cmd;
    logic [get_pkg::GRP_W-1:0]     group;
    logic [15:0]                   entry_id;
    logic [get_pkg::ATK_W-1:0]     attack;
    modport source (output valid, cmd, group, entry_id, attack, input ready);
    modport sink (input valid, cmd, group, entry_id, attack, output ready);
endinterface

interface get_res_if;
    logic                          valid;
    logic                          ready;
    logic [2:0]                    kind;
    logic [get_pkg::GRP_W-1:0]     result_group;
    logic [get_pkg::RID_W-1:0]     result_id;
    logic [get_pkg::TALLY_W-1:0]   tally;
    logic                          last;
    modport source (output valid, kind, result_group, result_id, tally, last, input ready);
    modport sink (input valid, kind, result_group, result_id, tally, last, output ready);
endinterface

[design/get_front.sv]
// Front part: accept commands, check group range, queue classified work.
module get_front (
    input  logic                 clk,
    input  logic                 rst_n,
    get_cmd_if.sink              cmd_in,
    input  logic [get_pkg::CFG_W-1:0] groups_in_use,
    output logic                 work_valid,
    input  logic                 work_ready,
    output get_pkg::work_t       work
);
    import get_pkg::*;

    work_t             q_reg [QDEPTH];
    logic [0:0]        wp_reg, rp_reg;
    logic [1:0]        cnt_reg;
    work_t             cls;
    logic              push, pop;

    // Classify the incoming transaction
    always_comb
    begin
        cls.grp = cmd_in.group;
        cls.id  = cmd_in.entry_id[ID_BITS-1:0];
        cls.atk = cmd_in.attack;
        if (cmd_in.cmd == CMD_REMOVE)
            cls.op = OP_REMOVE;
        else if ({1'b0, cmd_in.group} >= groups_in_use)
            cls.op = OP_ERROR;
        else
        begin
            unique case (cmd_t'(cmd_in.cmd))
                CMD_ENTER: cls.op = OP_ENTER;
                CMD_FIND:  cls.op = OP_FIND;
                default:   cls.op = OP_INFO;
            endcase
        end
    end

    assign cmd_in.ready = (cnt_reg != 2'(QDEPTH));
    assign push = cmd_in.valid && cmd_in.ready;
    assign pop  = work_valid && work_ready;
    assign work_valid = (cnt_reg != 2'd0);
    assign work = q_reg[rp_reg];

    // Hold payload entries
    always_ff @(posedge clk)
    begin
        if (push)
            q_reg[wp_reg] <= cls;
    end

    // Advance pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push) wp_reg <= wp_reg + 1'b1;
            if (pop)  rp_reg <= rp_reg + 1'b1;
            cnt_reg <= cnt_reg + 2'(push) - 2'(pop);
        end
    end
endmodule

[design/get_back.sv]
// Back part: ordered slot list, counts, scans and result register.
module get_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic [get_pkg::CFG_W-1:0] groups_in_use,
    input  logic                 work_valid,
    output logic                 work_ready,
    input  get_pkg::work_t       work,
    get_res_if.source            res
);
    import get_pkg::*;

    logic [GRP_W-1:0]   sgrp_reg [CAPACITY];
    logic [ID_BITS-1:0] sid_reg  [CAPACITY];
    logic [ATK_W-1:0]   satk_reg [CAPACITY];
    logic [TALLY_W-1:0] gcnt_reg [MAX_GROUPS];
    logic [USED_W-1:0]  used_reg, used_next;
    state_t             state_reg, state_next;
    work_t              cur_reg, cur_next;
    logic [SLOT_W-1:0]  idx_reg, idx_next;
    logic [TALLY_W-1:0] match_reg, match_next;
    logic [TALLY_W-1:0] seen_reg, seen_next;
    logic [SLOT_W-1:0]  best_reg, best_next;
    logic [GRP_W-1:0]   bgrp_reg, bgrp_next;
    logic               found_reg, found_next;
    result_t            out_reg, out_next;
    logic               ov_reg, ov_next;
    logic               take, out_free, hit, rhit, at_end;
    logic               do_insert, do_shift, do_dec;

    assign out_free = !ov_reg || res.ready;
    assign res.valid = ov_reg;
    assign res.kind = out_reg.kind;
    assign res.result_group = out_reg.grp;
    assign res.result_id = RID_W'(out_reg.id);
    assign res.tally = out_reg.tally;
    assign res.last = out_reg.last;

    assign hit  = (sgrp_reg[idx_reg] == cur_reg.grp) && (satk_reg[idx_reg] == cur_reg.atk);
    assign rhit = (sid_reg[idx_reg] == cur_reg.id)
                  && ({1'b0, sgrp_reg[idx_reg]} < groups_in_use)
                  && (!found_reg || sgrp_reg[idx_reg] < bgrp_reg);
    assign at_end = (USED_W'(idx_reg) + 1'b1 >= used_reg);
    assign work_ready = (state_reg == ST_IDLE);
    assign take = work_valid && work_ready;

    // Next state, scan counters and result register
    always_comb
    begin
        state_next = state_reg;
        cur_next   = cur_reg;
        idx_next   = idx_reg;
        match_next = match_reg;
        seen_next  = seen_reg;
        best_next  = best_reg;
        bgrp_next  = bgrp_reg;
        found_next = found_reg;
        used_next  = used_reg;
        out_next   = out_reg;
        ov_next    = ov_reg && !res.ready;
        do_insert  = 1'b0;
        do_shift   = 1'b0;
        do_dec     = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (take)
                begin
                    cur_next   = work;
                    idx_next   = '0;
                    match_next = '0;
                    seen_next  = '0;
                    found_next = 1'b0;
                    priority case (1'b1)
                        (work.op == OP_FIND || work.op == OP_REMOVE):
                            state_next = (used_reg == '0)
                                ? ((work.op == OP_FIND) ? ST_HEADER : ST_IDLE) : ST_COUNT;
                        default: state_next = ST_SINGLE;
                    endcase
                end
            end
            ST_COUNT:
            begin
                if (cur_reg.op == OP_FIND)
                begin
                    if (hit) match_next = match_reg + 1'b1;
                    idx_next = idx_reg + 1'b1;
                    if (at_end) state_next = ST_HEADER;
                end
                else
                begin
                    if (rhit)
                    begin
                        found_next = 1'b1;
                        best_next  = idx_reg;
                        bgrp_next  = sgrp_reg[idx_reg];
                    end
                    idx_next = idx_reg + 1'b1;
                    if (at_end)
                        state_next = (rhit || found_reg) ? ST_SHIFT : ST_IDLE;
                end
            end
            ST_HEADER:
            begin
                if (out_free)
                begin
                    out_next = '{KIND_HEADER, cur_reg.grp, '0, match_reg, match_reg == '0};
                    ov_next  = 1'b1;
                    idx_next = '0;
                    state_next = (match_reg == '0) ? ST_IDLE : ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (!hit)
                    idx_next = idx_reg + 1'b1;
                else if (out_free)
                begin
                    out_next = '{KIND_MEMBER, cur_reg.grp, sid_reg[idx_reg], '0,
                                 seen_reg + 1'b1 == match_reg};
                    ov_next   = 1'b1;
                    seen_next = seen_reg + 1'b1;
                    idx_next  = idx_reg + 1'b1;
                    if (seen_reg + 1'b1 == match_reg) state_next = ST_IDLE;
                end
            end
            ST_SHIFT:
            begin
                if (out_free)
                begin
                    do_shift  = 1'b1;
                    do_dec    = 1'b1;
                    used_next = used_reg - 1'b1;
                    out_next  = '{KIND_REMOVED, bgrp_reg, cur_reg.id, '0, 1'b1};
                    ov_next   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                if (out_free)
                begin
                    ov_next = 1'b1;
                    state_next = ST_IDLE;
                    out_next = '{KIND_ERROR, cur_reg.grp, '0, '0, 1'b1};
                    if (cur_reg.op == OP_ENTER && used_reg < USED_W'(CAPACITY))
                    begin
                        do_insert = 1'b1;
                        used_next = used_reg + 1'b1;
                        out_next  = '{KIND_ENTERED, cur_reg.grp, cur_reg.id, '0, 1'b1};
                    end
                    else if (cur_reg.op == OP_INFO)
                        out_next = '{KIND_INFO, cur_reg.grp, '0, gcnt_reg[cur_reg.grp], 1'b1};
                end
            end
        endcase
    end

    // Hold control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            used_reg  <= '0;
            ov_reg    <= 1'b0;
            found_reg <= 1'b0;
            for (int g = 0; g < MAX_GROUPS; g++)
                gcnt_reg[g] <= '0;
        end
        else
        begin
            state_reg <= state_next;
            used_reg  <= used_next;
            ov_reg    <= ov_next;
            found_reg <= found_next;
            if (do_insert)
                gcnt_reg[cur_reg.grp] <= gcnt_reg[cur_reg.grp] + 1'b1;
            else if (do_dec && gcnt_reg[bgrp_reg] != '0)
                gcnt_reg[bgrp_reg] <= gcnt_reg[bgrp_reg] - 1'b1;
        end
    end

    // Shift the slot list: insert at the front, close the gap on remove
    always_ff @(posedge clk)
    begin
        cur_reg   <= cur_next;
        idx_reg   <= idx_next;
        match_reg <= match_next;
        seen_reg  <= seen_next;
        best_reg  <= best_next;
        bgrp_reg  <= bgrp_next;
        out_reg   <= out_next;
        for (int s = 0; s < CAPACITY; s++)
        begin
            if (do_insert)
            begin
                if (s == 0)
                begin
                    sgrp_reg[s] <= cur_reg.grp;
                    sid_reg[s]  <= cur_reg.id;
                    satk_reg[s] <= cur_reg.atk;
                end
                else
                begin
                    sgrp_reg[s] <= sgrp_reg[s-1];
                    sid_reg[s]  <= sid_reg[s-1];
                    satk_reg[s] <= satk_reg[s-1];
                end
            end
            else if (do_shift && s + 1 < CAPACITY && SLOT_W'(s) >= best_reg)
            begin
                sgrp_reg[s] <= sgrp_reg[(s + 1) % CAPACITY];
                sid_reg[s]  <= sid_reg[(s + 1) % CAPACITY];
                satk_reg[s] <= satk_reg[(s + 1) % CAPACITY];
            end
        end
    end
endmodule

[design/grouped_entry_table_top.sv]
// Top level: grouped entry table with decoupled front and back parts.
//  channel  | direction | handshake   | payload
//  cmd_in   | in        | valid/ready | cmd, group, entry_id, attack
//  res_out  | out       | valid/ready | kind, result_group, result_id, tally, last
//  cfg      | in        | cfg_we      | cfg_wdata -> groups_in_use
// In the back part, enter, info and errors go through a single state; find counts
// matches over the used slots, sends the header, then scans up to the last match;
// remove scans used slots, then closes the gap if a group in use holds the id.
// A two-entry queue lets commands be taken while the back part works.
// Reset clears slot count, group counts and control; a stalled result holds.
module grouped_entry_table_top (
    input  logic                 clk,
    input  logic                 rst_n,
    get_cmd_if.sink              cmd_in,
    get_res_if.source            res_out,
    input  logic                 cfg_we,
    input  logic [get_pkg::CFG_W-1:0] cfg_wdata
);
    import get_pkg::*;

    logic [CFG_W-1:0] giu_reg;
    logic             work_valid, work_ready;
    work_t            work;

    // Clamp the register write to the supported range
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            giu_reg <= CFG_W'(MAX_GROUPS);
        else if (cfg_we)
        begin
            if (cfg_wdata == '0)
                giu_reg <= CFG_W'(1);
            else if (cfg_wdata > CFG_W'(MAX_GROUPS))
                giu_reg <= CFG_W'(MAX_GROUPS);
            else
                giu_reg <= cfg_wdata;
        end
    end

    get_front u_front (
        .clk(clk), .rst_n(rst_n), .cmd_in(cmd_in), .groups_in_use(giu_reg),
        .work_valid(work_valid), .work_ready(work_ready), .work(work)
    );

    get_back u_back (
        .clk(clk), .rst_n(rst_n), .groups_in_use(giu_reg),
        .work_valid(work_valid), .work_ready(work_ready), .work(work), .res(res_out)
    );

`ifndef SYNTHESIS
    a_kind_range: assert property (@(posedge clk) disable iff (!rst_n)
        res_out.valid |-> res_out.kind <= 3'd5)
        else $error("result kind out of range");
    a_tally_zero: assert property (@(posedge clk) disable iff (!rst_n)
        res_out.valid && (res_out.kind == KIND_MEMBER || res_out.kind == KIND_ENTERED)
        |-> res_out.tally == '0)
        else $error("tally set on id result");
    a_giu_range: assert property (@(posedge clk) disable iff (!rst_n)
        giu_reg != '0 && giu_reg <= CFG_W'(MAX_GROUPS))
        else $error("groups in use out of range");
`endif
endmodule

[test/tb_get_ifs.sv]
// Testbench interfaces: none needed beyond the design's own channel interfaces.
`timescale 1ns / 100ps
package tb_get_types;
    import get_pkg::*;
    typedef struct {
        logic [2:0]  kind;
        logic [3:0]  grp;
        logic [15:0] id;
        logic [5:0]  tally;
        logic        last;
    } outcome_t;
endpackage

[test/tb_grouped_entry_table_top.sv]
// Testbench top: drives commands and config, predicts and checks every result.
`timescale 1ns / 100ps
module tb_grouped_entry_table_top;
    import get_pkg::*;
    import tb_get_types::*;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [CFG_W-1:0] cfg_wdata;

    get_cmd_if cmd_ch ();
    get_res_if res_ch ();

    grouped_entry_table_top DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd_in   (cmd_ch),
        .res_out  (res_ch),
        .cfg_we   (cfg_we),
        .cfg_wdata(cfg_wdata)
    );

    // Shadow table: newest first
    logic [3:0]  tab_grp [CAPACITY];
    logic [15:0] tab_id  [CAPACITY];
    logic [15:0] tab_atk [CAPACITY];
    int          tab_used;
    int          grp_count [MAX_GROUPS];
    int          active_groups;

    outcome_t expected_q [$];
    int       errors;
    int       rx_stall_mode;   // 0 random, 1 no idling, 2 hold off
    int       tx_no_idle;

    // Clock
    initial clk = 1'b0;
    always #6 clk = ~clk;

    task automatic push_outcome(input logic [2:0] k, input logic [3:0] g,
                                input logic [15:0] i, input logic [5:0] t,
                                input logic l);
        outcome_t o;
        o.kind = k; o.grp = g; o.id = i; o.tally = t; o.last = l;
        expected_q.push_back(o);
    endtask

    // Predict results of one command and update the shadow table
    task automatic predict_command(input cmd_t c, input logic [3:0] g,
                                   input logic [15:0] eid, input logic [15:0] atk);
        int best;
        int hits;
        int seen;
        best = -1;
        hits = 0;
        seen = 0;
        if (c == CMD_REMOVE)
        begin
            for (int i = 0; i < tab_used; i++)
                if (tab_id[i] == eid && tab_grp[i] < active_groups)
                    if (best < 0 || tab_grp[i] < tab_grp[best])
                        best = i;
            if (best >= 0)
            begin
                push_outcome(KIND_REMOVED, tab_grp[best], eid, 0, 1'b1);
                grp_count[tab_grp[best]]--;
                for (int i = best; i + 1 < tab_used; i++)
                begin
                    tab_grp[i] = tab_grp[i+1];
                    tab_id[i]  = tab_id[i+1];
                    tab_atk[i] = tab_atk[i+1];
                end
                tab_used--;
            end
        end
        else if (g >= active_groups)
            push_outcome(KIND_ERROR, g, 0, 0, 1'b1);
        else if (c == CMD_ENTER)
        begin
            if (tab_used >= CAPACITY)
                push_outcome(KIND_ERROR, g, 0, 0, 1'b1);
            else
            begin
                for (int i = tab_used; i > 0; i--)
                begin
                    tab_grp[i] = tab_grp[i-1];
                    tab_id[i]  = tab_id[i-1];
                    tab_atk[i] = tab_atk[i-1];
                end
                tab_grp[0] = g; tab_id[0] = eid; tab_atk[0] = atk;
                tab_used++;
                grp_count[g]++;
                push_outcome(KIND_ENTERED, g, eid, 0, 1'b1);
            end
        end
        else if (c == CMD_FIND)
        begin
            for (int i = 0; i < tab_used; i++)
                if (tab_grp[i] == g && tab_atk[i] == atk)
                    hits++;
            push_outcome(KIND_HEADER, g, 0, hits[5:0], hits == 0);
            for (int i = 0; i < tab_used; i++)
                if (tab_grp[i] == g && tab_atk[i] == atk)
                begin
                    seen++;
                    push_outcome(KIND_MEMBER, g, tab_id[i], 0, seen == hits);
                end
        end
        else
            push_outcome(KIND_INFO, g, 0, grp_count[g][5:0], 1'b1);
    endtask

    // Send one command transaction, with random idling; valid stays up after acceptance
    task automatic send_command(input cmd_t c, input logic [3:0] g,
                                input logic [15:0] eid, input logic [15:0] atk);
        while (!tx_no_idle && $urandom_range(99) < 14)
        begin
            cmd_ch.valid <= 1'b0;
            @(posedge clk);
        end
        cmd_ch.valid    <= 1'b1;
        cmd_ch.cmd      <= c;
        cmd_ch.group    <= g;
        cmd_ch.entry_id <= eid;
        cmd_ch.attack   <= atk;
        @(posedge clk);
        while (!cmd_ch.ready)
            @(posedge clk);
        predict_command(c, g, eid, atk);
    endtask

    // Drop valid, wait until all results are in, then a settle pause
    task automatic drain_results();
        cmd_ch.valid <= 1'b0;
        while (expected_q.size() != 0)
            @(posedge clk);
        repeat (150) @(posedge clk);
    endtask

    task automatic write_groups(input int v);
        cfg_we    <= 1'b1;
        cfg_wdata <= v[4:0];
        @(posedge clk);
        cfg_we <= 1'b0;
        if (v < 1)
            active_groups = 1;
        else if (v > MAX_GROUPS)
            active_groups = MAX_GROUPS;
        else
            active_groups = v;
    endtask

    // Result channel ready: random stalls, no-idle and hold-off modes
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_ch.ready <= 1'b0;
        else if (rx_stall_mode == 2)
            res_ch.ready <= 1'b0;
        else if (rx_stall_mode == 1)
            res_ch.ready <= 1'b1;
        else
            res_ch.ready <= ($urandom_range(99) >= 14);
    end

    // Compare each result transaction with the oldest prediction
    always @(posedge clk)
    begin
        outcome_t o;
        if (rst_n && res_ch.valid && res_ch.ready)
        begin
            if (expected_q.size() == 0)
            begin
                $display("%0t: unexpected result kind=%0d grp=%0d id=%0d tally=%0d last=%0b",
                         $time, res_ch.kind, res_ch.result_group, res_ch.result_id,
                         res_ch.tally, res_ch.last);
                errors++;
            end
            else
            begin
                o = expected_q.pop_front();
                if (res_ch.kind !== o.kind || res_ch.result_group !== o.grp ||
                    res_ch.result_id !== o.id || res_ch.tally !== o.tally ||
                    res_ch.last !== o.last)
                begin
                    $display("%0t: mismatch expected kind=%0d grp=%0d id=%0d tally=%0d last=%0b",
                             $time, o.kind, o.grp, o.id, o.tally, o.last);
                    $display("%0t:          actual   kind=%0d grp=%0d id=%0d tally=%0d last=%0b",
                             $time, res_ch.kind, res_ch.result_group, res_ch.result_id,
                             res_ch.tally, res_ch.last);
                    errors++;
                end
            end
        end
    end

    // Directed: extremes, every operation, empty find, missing id, bad group
    task automatic test_directed();
        send_command(CMD_INFO, 4'd0, 16'd0, 16'd0);
        send_command(CMD_FIND, 4'd15, 16'd0, 16'hFFFF);
        send_command(CMD_REMOVE, 4'd0, 16'h1234, 16'd0);
        send_command(CMD_ENTER, 4'd0, 16'h0000, 16'h0000);
        send_command(CMD_ENTER, 4'd15, 16'hFFFF, 16'hFFFF);
        send_command(CMD_ENTER, 4'd15, 16'hAAAA, 16'hFFFF);
        send_command(CMD_ENTER, 4'd3, 16'hFFFF, 16'h5555);
        send_command(CMD_FIND, 4'd15, 16'd0, 16'hFFFF);
        send_command(CMD_FIND, 4'd0, 16'd0, 16'h0001);
        send_command(CMD_INFO, 4'd15, 16'd0, 16'd0);
        send_command(CMD_REMOVE, 4'd7, 16'hFFFF, 16'd0);
        send_command(CMD_REMOVE, 4'd0, 16'hFFFF, 16'd0);
        send_command(CMD_REMOVE, 4'd0, 16'hFFFF, 16'd0);
        drain_results();
        write_groups(4);
        send_command(CMD_ENTER, 4'd4, 16'h0101, 16'd1);
        send_command(CMD_FIND, 4'd9, 16'd0, 16'd1);
        send_command(CMD_INFO, 4'd15, 16'd0, 16'd0);
        send_command(CMD_REMOVE, 4'd0, 16'hAAAA, 16'd0);
        send_command(CMD_INFO, 4'd0, 16'd0, 16'd0);
        drain_results();
        write_groups(0);
        send_command(CMD_ENTER, 4'd1, 16'd5, 16'd5);
        send_command(CMD_ENTER, 4'd0, 16'd5, 16'd5);
        drain_results();
        write_groups(31);
        send_command(CMD_REMOVE, 4'd0, 16'hAAAA, 16'd0);
        drain_results();
    endtask

    // Fill the store to overflow, with the receiver holding off at first
    task automatic test_full_store();
        rx_stall_mode = 2;
        fork
            begin
                repeat (40) @(posedge clk);
                rx_stall_mode = 0;
            end
            for (int i = 0; i < 34; i++)
                send_command(CMD_ENTER, 4'($urandom_range(1, 0)), 16'($urandom_range(7)),
                             16'($urandom_range(1)));
        join
        for (int g = 0; g < 2; g++)
            for (int a = 0; a < 2; a++)
                send_command(CMD_FIND, 4'(g), 16'd0, 16'(a));
        drain_results();
        for (int i = 0; i < 34; i++)
            send_command(CMD_REMOVE, 4'd0, 16'($urandom_range(7)), 16'd0);
        drain_results();
    endtask

    // Random mix over a small id/attack space so finds and removes hit
    task automatic test_random(input int count, input int groups);
        cmd_t c;
        logic [15:0] eid;
        logic [15:0] atk;
        for (int n = 0; n < count; n++)
        begin
            c = cmd_t'($urandom_range(3));
            if (tab_used > 24 && c == CMD_ENTER)
                c = CMD_REMOVE;
            eid = ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(15));
            atk = ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(2));
            send_command(c, 4'($urandom_range(groups)), eid, atk);
        end
        drain_results();
    endtask

    // Limit
    initial
    begin
        #20ms;
        $display("grouped_entry_table_top test failed");
        $finish;
    end

    initial
    begin
        errors        = 0;
        tab_used      = 0;
        active_groups = MAX_GROUPS;
        rx_stall_mode = 0;
        tx_no_idle    = 0;
        for (int g = 0; g < MAX_GROUPS; g++)
            grp_count[g] = 0;
        rst_n           = 1'b0;
        cfg_we          = 1'b0;
        cfg_wdata       = '0;
        cmd_ch.valid    = 1'b0;
        cmd_ch.cmd      = '0;
        cmd_ch.group    = '0;
        cmd_ch.entry_id = '0;
        cmd_ch.attack   = '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_full_store();
        write_groups(16);
        test_random(40, 15);
        write_groups(3);
        test_random(40, 5);
        write_groups(1);
        test_random(20, 2);
        write_groups(16);
        rx_stall_mode = 1;
        tx_no_idle    = 1;
        test_random(40, 15);
        rx_stall_mode = 0;
        tx_no_idle    = 0;

        if (errors == 0)
            $display("grouped_entry_table_top test passed");
        else
            $display("grouped_entry_table_top test failed");
        $finish;
    end
endmodule
